>>> hw/rtl/rls_pkg.sv
`default_nettype none

package rls_pkg;

    // Payload widths that the stream format fixes
    localparam int LED_IDX_W  = 3;
    localparam int PAT_W      = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    // Command codes carried on s_tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAY_OFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMEMBER   = 2'd2;

    // Configuration reset values
    localparam logic [TICK_W-1:0] ON_TIMEOUT_RST = 16'd10000;
    localparam logic [TICK_W-1:0] STAY_OFF_RST   = 16'd10000;
    localparam logic [TICK_W-1:0] REMEMBER_RST   = 16'd500;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // One result beat, highest bit first
    typedef struct packed {
        logic                 blanked;
        logic                 blue_on;
        logic                 green_on;
        logic                 red_on;
        logic                 anode_on;
        logic [LED_IDX_W-1:0] active_led;
    } led_out_t;

    // Pattern bit at a scan position; slots past the stored width stay dark
    function automatic logic pat_bit(input logic [PAT_W-1:0] pat, input logic [4:0] bit_pos);
        logic on;
        on = 1'b0;
        if (bit_pos < 5'(PAT_W)) begin
            on = pat[bit_pos[2:0]];
        end
        return on;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rls_core.sv
`default_nettype none

module rls_core #(
    parameter int NUM_LEDS     = 3,
    parameter int PATTERN_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rls_pkg::TICK_W-1:0]    cfg_wdata,
    input  wire logic                          in_accept,
    input  wire logic                          in_cmd,
    input  wire logic [rls_pkg::LED_IDX_W-1:0] in_led_index,
    input  wire logic [rls_pkg::PAT_W-1:0]     in_red,
    input  wire logic [rls_pkg::PAT_W-1:0]     in_green,
    input  wire logic [rls_pkg::PAT_W-1:0]     in_blue,
    output logic                               res_valid,
    output rls_pkg::led_out_t                  res
);
    import rls_pkg::*;

    localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int BIT_W = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(PATTERN_BITS - 1);

    logic [TICK_W-1:0] on_timeout_reg, stay_off_reg, remember_reg;

    logic [PAT_W-1:0] red_store_reg   [NUM_LEDS];
    logic [PAT_W-1:0] green_store_reg [NUM_LEDS];
    logic [PAT_W-1:0] blue_store_reg  [NUM_LEDS];

    logic [LED_W-1:0]  scan_led_reg, scan_led_next;
    logic [BIT_W-1:0]  scan_bit_reg, scan_bit_next;
    logic [TICK_W-1:0] idle_ticks_reg, idle_ticks_next;
    logic [TICK_W-1:0] off_ticks_reg, off_ticks_next;
    logic              short_to_reg, short_to_next;
    logic              off_mode_reg, off_mode_next;
    logic              pending_reg, pending_next;

    logic              is_set, is_tick, idx_ok;
    logic [TICK_W-1:0] limit, off_sat;
    logic [4:0]        bit_pos;

    assign is_set  = in_accept && (in_cmd == CMD_SET);
    assign is_tick = in_accept && (in_cmd == CMD_TICK);
    assign idx_ok  = 4'(in_led_index) < 4'(NUM_LEDS);
    assign limit   = short_to_reg ? remember_reg : on_timeout_reg;
    assign off_sat = (off_ticks_reg == TICK_MAX) ? off_ticks_reg : off_ticks_reg + 1'b1;
    assign bit_pos = 5'(scan_bit_reg);

    // Result of a tick, taken by the output buffer when res_valid
    always_comb begin
        res_valid      = is_tick;
        res.active_led = LED_IDX_W'(scan_led_reg);
        res.blanked    = off_mode_reg;
        res.anode_on   = !off_mode_reg;
        res.red_on     = !off_mode_reg && pat_bit(red_store_reg[scan_led_reg], bit_pos);
        res.green_on   = !off_mode_reg && pat_bit(green_store_reg[scan_led_reg], bit_pos);
        res.blue_on    = !off_mode_reg && pat_bit(blue_store_reg[scan_led_reg], bit_pos);
    end

    always_comb begin
        scan_led_next   = scan_led_reg;
        scan_bit_next   = scan_bit_reg;
        idle_ticks_next = idle_ticks_reg;
        off_ticks_next  = off_ticks_reg;
        short_to_next   = short_to_reg;
        off_mode_next   = off_mode_reg;
        pending_next    = pending_reg;
        if (is_set) begin
            if (off_mode_reg) begin
                off_mode_next   = 1'b0;
                off_ticks_next  = '0;
                short_to_next   = 1'b0;
                idle_ticks_next = '0;
                pending_next    = 1'b0;
            end else begin
                pending_next = 1'b1;
            end
        end else if (is_tick) begin
            if (off_mode_reg) begin
                off_ticks_next = off_sat;
                if (off_sat >= stay_off_reg) begin
                    off_mode_next   = 1'b0;
                    off_ticks_next  = '0;
                    short_to_next   = 1'b1;
                    idle_ticks_next = '0;
                end
            end else begin
                // advance the scan: LEDs first, then the bit slot
                if (scan_led_reg == LED_LAST) begin
                    scan_led_next = '0;
                    scan_bit_next = (scan_bit_reg == BIT_LAST) ? '0 : scan_bit_reg + 1'b1;
                end else begin
                    scan_led_next = scan_led_reg + 1'b1;
                end
                if (pending_reg) begin
                    pending_next    = 1'b0;
                    idle_ticks_next = '0;
                    short_to_next   = 1'b0;
                end else if (idle_ticks_reg >= limit) begin
                    off_mode_next  = 1'b1;
                    off_ticks_next = '0;
                end else if (idle_ticks_reg != TICK_MAX) begin
                    idle_ticks_next = idle_ticks_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_timeout_reg <= ON_TIMEOUT_RST;
            stay_off_reg   <= STAY_OFF_RST;
            remember_reg   <= REMEMBER_RST;
            scan_led_reg   <= '0;
            scan_bit_reg   <= '0;
            idle_ticks_reg <= '0;
            off_ticks_reg  <= '0;
            short_to_reg   <= 1'b0;
            off_mode_reg   <= 1'b0;
            pending_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ON_TIMEOUT: on_timeout_reg <= cfg_wdata;
                    CFG_STAY_OFF:   stay_off_reg   <= cfg_wdata;
                    CFG_REMEMBER:   remember_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            scan_led_reg   <= scan_led_next;
            scan_bit_reg   <= scan_bit_next;
            idle_ticks_reg <= idle_ticks_next;
            off_ticks_reg  <= off_ticks_next;
            short_to_reg   <= short_to_next;
            off_mode_reg   <= off_mode_next;
            pending_reg    <= pending_next;
        end
    end

    // Pattern stores clear on reset; out-of-range index writes nothing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                red_store_reg[i]   <= '0;
                green_store_reg[i] <= '0;
                blue_store_reg[i]  <= '0;
            end
        end else if (is_set && idx_ok) begin
            red_store_reg[in_led_index[LED_W-1:0]]   <= in_red;
            green_store_reg[in_led_index[LED_W-1:0]] <= in_green;
            blue_store_reg[in_led_index[LED_W-1:0]]  <= in_blue;
        end
    end

    a_off_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        off_mode_reg |-> !pending_reg) else $error("change pending while blanked");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_led_reg <= LED_LAST) else $error("scan LED out of range");

    a_scan_hold_off: assert property (@(posedge aclk) disable iff (!aresetn)
        off_mode_reg |=> $stable(scan_led_reg) && $stable(scan_bit_reg))
        else $error("scan moved while blanked");

endmodule

`default_nettype wire

>>> hw/rtl/rls_skid.sv
`default_nettype none

module rls_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire rls_pkg::led_out_t in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output rls_pkg::led_out_t      out_data,
    input  wire logic              out_ready
);
    import rls_pkg::*;

    logic     out_valid_reg, skid_valid_reg;
    led_out_t out_data_reg, skid_data_reg;
    logic     push, pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (push) begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg) else $error("skid full with output empty");

endmodule

`default_nettype wire

>>> hw/rtl/rgb_led_scan_with_autooff.sv
`default_nettype none

// Multiplexed RGB LED scanner with auto-off.
// Throughput: one beat per cycle while s_tready is high, ticks and set commands alike.
// A tick's result is registered in the output buffer and shown on m_tdata from there;
// a two-entry output buffer keeps input flowing while one result waits.
// Reset (aresetn low, synchronous): patterns cleared, scan at LED 0 bit 0,
// block lit, counters zero, timeouts back to 10000 / 10000 / 500 ticks.
module rgb_led_scan_with_autooff #(
    parameter int NUM_LEDS     = 3,
    parameter int PATTERN_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rls_pkg::TICK_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [2:0] led_index, [10:3] red_pattern, [18:11] green_pattern,
    // [26:19] blue_pattern, [31:27] zero
    input  wire logic [rls_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  wire logic                          s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [2:0] active_led, [3] anode_on, [4] red_on, [5] green_on,
    // [6] blue_on, [7] blanked
    output logic [rls_pkg::M_TDATA_W-1:0]      m_tdata
);
    import rls_pkg::*;

    logic     in_accept;
    logic     res_valid;
    led_out_t res;
    led_out_t out_data;

    // A beat is taken whenever the output buffer has a free slot
    assign in_accept = s_tvalid && s_tready;

    rls_core #(
        .NUM_LEDS     (NUM_LEDS),
        .PATTERN_BITS (PATTERN_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_accept    (in_accept),
        .in_cmd       (s_tuser),
        .in_led_index (s_tdata[2:0]),
        .in_red       (s_tdata[10:3]),
        .in_green     (s_tdata[18:11]),
        .in_blue      (s_tdata[26:19]),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Register results; the skid slot holds one more while m_tready is low
    rls_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = M_TDATA_W'(out_data);

endmodule

`default_nettype wire
